// File: rtl/tptb_pkg.sv
// ----------------------------------------------------------------------------
// tptb_pkg: shared types and constants of the timer bank
// op codes, result word and command word, which is also the queue entry
// ----------------------------------------------------------------------------
package tptb_pkg;

  localparam int unsigned TimerCount = 16;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned TickW      = 64;
  localparam int unsigned QDepth     = 2;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_ARM    = 3'd2,
    OP_CANCEL = 3'd3,
    OP_TICK   = 3'd4,
    OP_WAIT   = 3'd5,
    OP_RSV6   = 3'd6,
    OP_RSV7   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOT_USE = 2'd2,
    ST_NOT_SIG = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [SlotW-1:0] timer_index;
    logic             manual_reset_flag;
    logic [TickW-1:0] expire_at;
    logic [TickW-1:0] reload_len;
    logic [TickW-1:0] tick_now;
  } cmd_t;

  typedef struct packed {
    logic             kind;
    logic [SlotW-1:0] slot;
    logic [1:0]       status;
    logic             last;
  } res_t;

endpackage

// File: rtl/tick_polled_timer_bank.sv
// ----------------------------------------------------------------------------
// tick_polled_timer_bank: bank of waitable one-shot and periodic timers
// Usage: drive cmd_i and raise start; the word is taken at a clock edge
// where start is high and busy is low. Commands enter a two-entry queue
// so a new word can be taken while the back end is still working; busy
// is high while the queue is full.
// Results leave on res_o marked by res_valid_o for one cycle each; the
// receiver must take them, it cannot stall. Every command ends with one
// result that has last set.
// With the back end idle, allocate, free, arm, cancel and wait pass the
// queue and a registered result stage. A tick scans the 16 slots one per
// cycle while no periodic slot fires and ends with a done word; each
// periodic slot that fires holds the scan while the 64 bit shift divider
// runs and its reload is written.
// Throughput: one command per back end run; later commands wait in the queue.
// Reset clears all slots at once; no command is taken during reset.
// ----------------------------------------------------------------------------
module tick_polled_timer_bank
  import tptb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  cmd_t cmd_i,
  output logic busy,
  output logic res_valid_o,
  output res_t res_o
);

  logic q_valid, q_pop, full, idle;
  cmd_t q_cmd;

  assign busy = full;

  tptb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cmd_i     (cmd_i),
    .full_o    (full),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  tptb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .idle_o      (idle),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_fire_notlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind) |-> !res_o.last) else $error("fire marked last");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle && !busy) |=> !res_valid_o || res_o.last) else $error("stray result");

endmodule

// File: rtl/tptb_front.sv
// ----------------------------------------------------------------------------
// tptb_front: command intake
// takes command words and holds them in a short queue for the back end
// ----------------------------------------------------------------------------
module tptb_front
  import tptb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic q_valid_o,
  output cmd_t q_cmd_o,
  input  logic q_pop_i
);

  cmd_t       mem_q [QDepth];
  logic [0:0] wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign full_o    = (cnt_q == 2'(QDepth));
  assign push      = start_i && !full_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

// File: rtl/tptb_divider.sv
// ----------------------------------------------------------------------------
// tptb_divider: 64 bit restoring divider
// one quotient bit per cycle, remainder out
// ----------------------------------------------------------------------------
module tptb_divider
  import tptb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [TickW-1:0] num_i,
  input  logic [TickW-1:0] den_i,
  output logic             done_o,
  output logic [TickW-1:0] rem_o
);

  logic [TickW-1:0] quot_q, den_q, rem_q;
  logic [TickW:0]   trial;
  logic [6:0]       cnt_q;
  logic             busy_q;

  assign trial  = {rem_q, quot_q[TickW-1]} - {1'b0, den_q};
  assign rem_o  = rem_q;
  assign done_o = busy_q && (cnt_q == 7'd0);

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quot_q <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
    end else if (busy_q && cnt_q != 7'd0) begin
      if (!trial[TickW]) begin
        rem_q  <= trial[TickW-1:0];
        quot_q <= {quot_q[TickW-2:0], 1'b1};
      end else begin
        rem_q  <= {rem_q[TickW-2:0], quot_q[TickW-1]};
        quot_q <= {quot_q[TickW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'(TickW);
    end else if (busy_q) begin
      if (cnt_q == 7'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 7'd1;
    end
  end

endmodule

// File: rtl/tptb_back.sv
// ----------------------------------------------------------------------------
// tptb_back: command execution
// slot state, sequential tick scan and periodic reload
// ----------------------------------------------------------------------------
module tptb_back
  import tptb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t q_cmd_i,
  output logic q_pop_o,
  output logic idle_o,
  output logic res_valid_o,
  output res_t res_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_DIV  = 5'b00100,
    S_LOAD = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [TimerCount-1:0] use_q, arm_q, man_q, sig_q;
  logic [TickW-1:0] due_q [TimerCount];
  logic [TickW-1:0] per_q [TimerCount];
  logic [TickW-1:0] now_q;
  logic [SlotW-1:0] idx_q;
  logic             res_v_q, res_v_d;
  res_t             res_q, idle_res;
  logic             div_go, div_done;
  logic [TickW-1:0] div_rem;
  logic             valid_cmd, hit, have_free;
  logic [SlotW-1:0] free_idx;
  logic [TickW-1:0] cur_due, cur_per;

  assign cur_due = due_q[idx_q];
  assign cur_per = per_q[idx_q];
  assign hit = use_q[idx_q] && arm_q[idx_q] && (cur_due <= now_q);
  assign valid_cmd = use_q[q_cmd_i.timer_index];
  assign idle_o = (state_q == S_IDLE) && !q_valid_i;
  assign res_valid_o = res_v_q;
  assign res_o = res_q;
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign div_go = (state_q == S_SCAN) && hit && (cur_per != '0);
  assign res_v_d = ((state_q == S_IDLE) && q_valid_i && (op_e'(q_cmd_i.op) != OP_TICK)) ||
                   ((state_q == S_SCAN) && hit) || (state_q == S_DONE);

  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = TimerCount - 1; i >= 0; i--) begin
      if (!use_q[i]) begin
        have_free = 1'b1;
        free_idx  = SlotW'(i);
      end
    end
  end

  always_comb begin
    idle_res = '{kind: 1'b0, slot: '0, status: ST_OK, last: 1'b1};
    case (op_e'(q_cmd_i.op))
      OP_ALLOC: begin
        if (have_free) idle_res.slot = free_idx;
        else idle_res.status = ST_FULL;
      end
      OP_FREE, OP_CANCEL, OP_ARM: begin
        if (!valid_cmd) idle_res.status = ST_NOT_USE;
      end
      OP_WAIT: begin
        if (!valid_cmd) idle_res.status = ST_NOT_USE;
        else if (!sig_q[q_cmd_i.timer_index]) idle_res.status = ST_NOT_SIG;
      end
      default: ;
    endcase
  end

  tptb_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (now_q - cur_due),
    .den_i  (cur_per),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (q_valid_i && op_e'(q_cmd_i.op) == OP_TICK) state_d = S_SCAN;
      S_SCAN: begin
        if (div_go) state_d = S_DIV;
        else if (idx_q == SlotW'(TimerCount - 1)) state_d = S_DONE;
      end
      S_DIV:  if (div_done) state_d = S_LOAD;
      S_LOAD: state_d = (idx_q == SlotW'(TimerCount - 1)) ? S_DONE : S_SCAN;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) now_q <= q_cmd_i.tick_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      use_q <= '0;
      arm_q <= '0;
      man_q <= '0;
      sig_q <= '0;
      idx_q <= '0;
      res_v_q <= 1'b0;
      res_q <= '0;
      for (int i = 0; i < TimerCount; i++) begin
        due_q[i] <= '0;
        per_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      res_v_q <= res_v_d;
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (q_valid_i) begin
            res_q <= idle_res;
            case (op_e'(q_cmd_i.op))
              OP_ALLOC: begin
                if (have_free) begin
                  use_q[free_idx] <= 1'b1;
                  arm_q[free_idx] <= 1'b0;
                  man_q[free_idx] <= q_cmd_i.manual_reset_flag;
                  sig_q[free_idx] <= 1'b0;
                  due_q[free_idx] <= '0;
                  per_q[free_idx] <= '0;
                end
              end
              OP_FREE, OP_CANCEL: begin
                if (valid_cmd) begin
                  if (op_e'(q_cmd_i.op) == OP_FREE) begin
                    use_q[q_cmd_i.timer_index] <= 1'b0;
                    man_q[q_cmd_i.timer_index] <= 1'b0;
                  end
                  arm_q[q_cmd_i.timer_index] <= 1'b0;
                  sig_q[q_cmd_i.timer_index] <= 1'b0;
                  due_q[q_cmd_i.timer_index] <= '0;
                  per_q[q_cmd_i.timer_index] <= '0;
                end
              end
              OP_ARM: begin
                if (valid_cmd) begin
                  arm_q[q_cmd_i.timer_index] <= 1'b1;
                  sig_q[q_cmd_i.timer_index] <= 1'b0;
                  due_q[q_cmd_i.timer_index] <= q_cmd_i.expire_at;
                  per_q[q_cmd_i.timer_index] <= q_cmd_i.reload_len;
                end
              end
              OP_WAIT: begin
                if (valid_cmd && sig_q[q_cmd_i.timer_index] &&
                    !man_q[q_cmd_i.timer_index])
                  sig_q[q_cmd_i.timer_index] <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            sig_q[idx_q] <= 1'b1;
            res_q <= '{kind: 1'b1, slot: idx_q, status: ST_OK, last: 1'b0};
            if (cur_per == '0) begin
              arm_q[idx_q] <= 1'b0;
              due_q[idx_q] <= '0;
            end
          end
          if (!div_go) idx_q <= idx_q + 1'b1;
        end
        S_DIV: ;
        S_LOAD: begin
          // next due is now - (now - due) mod period + period
          due_q[idx_q] <= now_q - div_rem + cur_per;
          idx_q <= idx_q + 1'b1;
        end
        S_DONE: begin
          res_q <= '{kind: 1'b0, slot: '0, status: ST_OK, last: 1'b1};
        end
        default: ;
      endcase
    end
  end

endmodule
